/* design/mandelbrot_pixel_engine_top_assert.svh */
// Assertion macros for the Mandelbrot pixel engine checker.
// Used by mpe_checker.sv; needs clk_i and rst_ni in scope.
`ifndef MANDELBROT_PIXEL_ENGINE_TOP_ASSERT_SVH
`define MANDELBROT_PIXEL_ENGINE_TOP_ASSERT_SVH

// clocked assertion, off during reset
`define MPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion, also checked during reset
`define MPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* design/mpe_pkg.sv */
// Shared types, constants and fixed-point helpers of the Mandelbrot pixel engine.
// No dependencies.
package mpe_pkg;

  localparam logic [47:0] QMAX  = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] QMIN  = 48'h8000_0000_0000;
  localparam logic [7:0]  ALPHA = 8'hFF;

  typedef enum logic [2:0] {
    CFG_WIDTH      = 3'd0,
    CFG_HEIGHT     = 3'd1,
    CFG_MAX_ITER   = 3'd2,
    CFG_CENTER_RE  = 3'd3,
    CFG_CENTER_IM  = 3'd4,
    CFG_RANGE_LOW  = 3'd5,
    CFG_RANGE_HIGH = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DO_XY,   // index div/mod width
    DO_S,    // 4w / 5h aspect scale
    DO_RX,   // x / w
    DO_RY    // y / h
  } div_op_e;

  typedef enum logic [2:0] {
    MO_TX,
    MO_TY,
    MO_CRE,
    MO_CIM,
    MO_RR,
    MO_II,
    MO_RI
  } mul_op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIV_XY,
    ST_DIV_S,
    ST_DIV_RX,
    ST_MUL_TX,
    ST_MUL_CRE,
    ST_DIV_RY,
    ST_MUL_TY,
    ST_MUL_CIM,
    ST_MUL_RR0,
    ST_MUL_II0,
    ST_LOOP,
    ST_MUL_RI,
    ST_UPDATE,
    ST_MUL_RR,
    ST_MUL_II,
    ST_CHECK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic    load;
    logic    div_start;
    div_op_e div_op;
    logic    mul_start;
    mul_op_e mul_op;
    logic    update;
    logic    it_inc;
    logic    set_color;
    logic    set_black;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic last;
    logic escaped;
  } sts_t;

  function automatic logic [47:0] qadd(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {a[47], a} + {b[47], b};
    if (s[48] != s[47]) begin
      qadd = s[48] ? QMIN : QMAX;
    end else begin
      qadd = s[47:0];
    end
  endfunction

  function automatic logic [47:0] qsub(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {a[47], a} - {b[47], b};
    if (s[48] != s[47]) begin
      qsub = s[48] ? QMIN : QMAX;
    end else begin
      qsub = s[47:0];
    end
  endfunction

  localparam logic [23:0] FIRE_ROM [256] = '{
    24'd0, 24'd0, 24'd4, 24'd12, 24'd16, 24'd24, 24'd32, 24'd36, 24'd44, 24'd48, 24'd56,
    24'd64, 24'd68, 24'd76, 24'd80, 24'd88, 24'd96, 24'd100, 24'd108, 24'd116, 24'd120,
    24'd128, 24'd132, 24'd140, 24'd148, 24'd152, 24'd160, 24'd164, 24'd172, 24'd180,
    24'd184, 24'd192, 24'd200,
    24'd1224, 24'd3272, 24'd4300, 24'd6348, 24'd7376, 24'd9424, 24'd10448, 24'd12500,
    24'd14548, 24'd15576, 24'd17624,
    24'd18648, 24'd20700, 24'd21724, 24'd23776, 24'd25824, 24'd26848, 24'd28900,
    24'd29924, 24'd31976, 24'd33000, 24'd35048,
    24'd36076, 24'd38124, 24'd40176, 24'd41200, 24'd43248, 24'd44276, 24'd46324,
    24'd47352, 24'd49400, 24'd51452, 24'd313596,
    24'd837884, 24'd1363196, 24'd1887484, 24'd2412796, 24'd2937084, 24'd3461372,
    24'd3986684, 24'd4510972, 24'd5036284, 24'd5560572, 24'd6084860,
    24'd6610172, 24'd7134460, 24'd7659772, 24'd8184060, 24'd8708348, 24'd9233660,
    24'd9757948, 24'd10283260, 24'd10807548, 24'd11331836, 24'd11857148,
    24'd12381436, 24'd12906748, 24'd13431036, 24'd13955324, 24'd14480636, 24'd15004924,
    24'd15530236, 24'd16054524, 24'd16579836, 24'd16317692, 24'd16055548,
    24'd15793404, 24'd15269116, 24'd15006972, 24'd14744828, 24'd14220540, 24'd13958396,
    24'd13696252, 24'd13171964, 24'd12909820, 24'd12647676, 24'd12123388,
    24'd11861244, 24'd11599100, 24'd11074812, 24'd10812668, 24'd10550524, 24'd10288380,
    24'd9764092, 24'd9501948, 24'd9239804, 24'd8715516, 24'd8453372,
    24'd8191228, 24'd7666940, 24'd7404796, 24'd7142652, 24'd6618364, 24'd6356220,
    24'd6094076, 24'd5569788, 24'd5307644, 24'd5045500, 24'd4783356,
    24'd4259068, 24'd3996924, 24'd3734780, 24'd3210492, 24'd2948348, 24'd2686204,
    24'd2161916, 24'd1899772, 24'd1637628, 24'd1113340, 24'd851196,
    24'd589052, 24'd64764, 24'd63740, 24'd62716, 24'd61692, 24'd59644, 24'd58620,
    24'd57596, 24'd55548, 24'd54524, 24'd53500,
    24'd51452, 24'd50428, 24'd49404, 24'd47356, 24'd46332, 24'd45308, 24'd43260,
    24'd42236, 24'd41212, 24'd40188, 24'd38140,
    24'd37116, 24'd36092, 24'd34044, 24'd33020, 24'd31996, 24'd29948, 24'd28924,
    24'd27900, 24'd25852, 24'd24828, 24'd23804,
    24'd21756, 24'd20732, 24'd19708, 24'd18684, 24'd16636, 24'd15612, 24'd14588,
    24'd12540, 24'd11516, 24'd10492, 24'd8444,
    24'd7420, 24'd6396, 24'd4348, 24'd3324, 24'd2300, 24'd252, 24'd248, 24'd244,
    24'd240, 24'd236, 24'd232,
    24'd228, 24'd224, 24'd220, 24'd216, 24'd212, 24'd208, 24'd204, 24'd200, 24'd196,
    24'd192, 24'd188,
    24'd184, 24'd180, 24'd176, 24'd172, 24'd168, 24'd164, 24'd160, 24'd156, 24'd152,
    24'd148, 24'd144,
    24'd140, 24'd136, 24'd132, 24'd128, 24'd124, 24'd120, 24'd116, 24'd112, 24'd108,
    24'd104, 24'd100,
    24'd96, 24'd92, 24'd88, 24'd84, 24'd80, 24'd76, 24'd72, 24'd68, 24'd64, 24'd60,
    24'd56,
    24'd52, 24'd48, 24'd44, 24'd40, 24'd36, 24'd32, 24'd28, 24'd24, 24'd20, 24'd16,
    24'd12,
    24'd8, 24'd0, 24'd0
  };

endpackage

/* design/mpe_mul.sv */
// Sequential saturating Q multiplier: one 24x24 partial product per cycle.
// Depends on mpe_pkg.
module mpe_mul #(
  parameter int unsigned FRAC_BITS = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] a_i,
  input  logic [47:0] b_i,
  output logic        done_o,
  output logic [47:0] res_o
);

  localparam logic [95:0] REM_MASK = (96'd1 << FRAC_BITS) - 96'd1;

  logic        busy_q, fin_q, done_q, neg_q;
  logic [1:0]  cnt_q;
  logic [47:0] ma_q, mb_q, res_q;
  logic [95:0] acc_q;

  logic [23:0] ah, bh;
  logic [47:0] pp;
  logic [6:0]  sh;
  logic [95:0] q, qn;
  logic        rem;
  logic [47:0] res_d;

  assign ah = cnt_q[1] ? ma_q[47:24] : ma_q[23:0];
  assign bh = cnt_q[0] ? mb_q[47:24] : mb_q[23:0];
  assign pp = ah * bh;
  assign sh = (cnt_q[1] ? 7'd24 : 7'd0) + (cnt_q[0] ? 7'd24 : 7'd0);

  // drop the fraction, floor for negative results, then saturate
  always_comb begin
    q   = acc_q >> FRAC_BITS;
    rem = |(acc_q & REM_MASK);
    qn  = q + {95'd0, rem};
    if (neg_q) begin
      res_d = (qn > 96'h8000_0000_0000) ? mpe_pkg::QMIN : (~qn[47:0] + 48'd1);
    end else begin
      res_d = (q > 96'h7FFF_FFFF_FFFF) ? mpe_pkg::QMAX : q[47:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= a_i[47] ^ b_i[47];
      ma_q  <= a_i[47] ? (~a_i + 48'd1) : a_i;
      mb_q  <= b_i[47] ? (~b_i + 48'd1) : b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + ({48'd0, pp} << sh);
    end
    if (fin_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* design/mpe_div.sv */
// Restoring divider, one quotient bit per cycle; integer or fractional quotient.
// Depends on nothing but its parameters.
module mpe_div #(
  parameter int unsigned FRAC_BITS = 40,
  parameter int unsigned MAX_DIM   = 4096,
  localparam int unsigned NW = 24 + FRAC_BITS,
  localparam int unsigned DW = $clog2(5 * MAX_DIM + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          int_mode_i,
  input  logic [23:0]   num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] dvd_q, quo_q;
  logic [DW-1:0] rem_q, den_q;
  logic [DW:0]   trial, diff;
  logic          ge;

  assign trial = {rem_q, dvd_q[NW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= int_mode_i ? CW'(24) : CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= NW'(num_i) << FRAC_BITS;
      quo_q <= '0;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
      dvd_q <= dvd_q << 1;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

/* design/mpe_dp.sv */
// Datapath: config registers, coordinate and orbit registers, divider, multiplier.
// Depends on mpe_pkg, mpe_div and mpe_mul.
module mpe_dp #(
  parameter int unsigned FRAC_BITS = 40,
  parameter int unsigned MAX_DIM   = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [47:0]        cfg_wdata_i,
  input  logic [23:0]        pixel_index_i,
  input  mpe_pkg::cmd_t      cmd_i,
  output mpe_pkg::sts_t      sts_o,
  output logic [23:0]        out_index_o,
  output logic [31:0]        argb_color_o
);

  localparam int unsigned NW  = 24 + FRAC_BITS;
  localparam int unsigned DW  = $clog2(5 * MAX_DIM + 1);
  localparam int unsigned QW  = (NW > 48) ? NW : 48;
  localparam int unsigned EW  = (FRAC_BITS + 3 > 49) ? FRAC_BITS + 3 : 49;
  localparam logic [63:0] HALF64 = 64'd1 << (FRAC_BITS - 1);
  localparam logic [63:0] TWO64  = 64'd2 << FRAC_BITS;
  localparam logic [47:0] RST_CRE  = (FRAC_BITS <= 47) ? HALF64[47:0] : mpe_pkg::QMAX;
  localparam logic [47:0] RST_HIGH = (FRAC_BITS <= 45) ? TWO64[47:0] : mpe_pkg::QMAX;
  localparam logic [47:0] RST_LOW  =
    (FRAC_BITS <= 46) ? (~TWO64[47:0] + 48'd1) : mpe_pkg::QMIN;
  localparam logic [EW-1:0] FOUR = EW'(4) << FRAC_BITS;

  // configuration
  logic [12:0] fw_q, fh_q;
  logic [15:0] max_iter_q;
  logic [47:0] center_re_q, center_im_q, range_low_q, range_high_q;

  // per-item state
  logic [23:0] idx_q, y_q;
  logic [12:0] x_q;
  logic [15:0] it_q;
  logic [47:0] s_q, ratio_q, t_q, cre_q, cim_q, zr_q, zi_q, rr_q, ii_q, ri_q;
  logic [31:0] color_q;
  mpe_pkg::div_op_e div_op_q;
  mpe_pkg::mul_op_e mul_op_q;

  logic [12:0]   wc, hc;
  logic [47:0]   span;
  logic [23:0]   div_num;
  logic [DW-1:0] div_den, wden, hden;
  logic          div_int, div_done, mul_done;
  logic [NW-1:0] div_quo;
  logic [DW-1:0] div_rem;
  logic [QW-1:0] quo_ext;
  logic [47:0]   ratio, mul_a, mul_b, mul_res;
  logic [EW-1:0] mag2;

  assign wc = (fw_q == 13'd0) ? 13'd1 : ((fw_q > 13'(MAX_DIM)) ? 13'(MAX_DIM) : fw_q);
  assign hc = (fh_q == 13'd0) ? 13'd1 : ((fh_q > 13'(MAX_DIM)) ? 13'(MAX_DIM) : fh_q);
  assign wden = DW'(wc);
  assign hden = DW'(hc);
  assign span = mpe_pkg::qsub(range_high_q, range_low_q);

  always_comb begin
    div_int = 1'b0;
    case (cmd_i.div_op)
      mpe_pkg::DO_XY: begin
        div_num = idx_q;
        div_den = wden;
        div_int = 1'b1;
      end
      mpe_pkg::DO_S: begin
        div_num = 24'(wc) << 2;
        div_den = (hden << 2) + hden;
      end
      mpe_pkg::DO_RX: begin
        div_num = 24'(x_q);
        div_den = wden;
      end
      mpe_pkg::DO_RY: begin
        div_num = y_q;
        div_den = hden;
      end
      default: begin
        div_num = idx_q;
        div_den = wden;
      end
    endcase
  end

  always_comb begin
    case (cmd_i.mul_op)
      mpe_pkg::MO_TX, mpe_pkg::MO_TY: begin
        mul_a = span;
        mul_b = ratio_q;
      end
      mpe_pkg::MO_CRE, mpe_pkg::MO_CIM: begin
        mul_a = s_q;
        mul_b = t_q;
      end
      mpe_pkg::MO_RR: begin
        mul_a = zr_q;
        mul_b = zr_q;
      end
      mpe_pkg::MO_II: begin
        mul_a = zi_q;
        mul_b = zi_q;
      end
      mpe_pkg::MO_RI: begin
        mul_a = zr_q;
        mul_b = zi_q;
      end
      default: begin
        mul_a = zr_q;
        mul_b = zr_q;
      end
    endcase
  end

  mpe_div #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_DIM   (MAX_DIM)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .int_mode_i (div_int),
    .num_i      (div_num),
    .den_i      (div_den),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  mpe_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  // quotient saturates at the largest Q value
  assign quo_ext = QW'(div_quo);
  assign ratio   = (quo_ext > QW'(mpe_pkg::QMAX)) ? mpe_pkg::QMAX : quo_ext[47:0];

  // squares are never negative, so the sum cannot wrap
  assign mag2 = EW'(rr_q) + EW'(ii_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q         <= 13'd640;
      fh_q         <= 13'd480;
      max_iter_q   <= 16'd200;
      center_re_q  <= RST_CRE;
      center_im_q  <= 48'd0;
      range_low_q  <= RST_LOW;
      range_high_q <= RST_HIGH;
    end else if (cfg_we_i) begin
      case (mpe_pkg::cfg_idx_e'(cfg_idx_i))
        mpe_pkg::CFG_WIDTH:      fw_q         <= cfg_wdata_i[12:0];
        mpe_pkg::CFG_HEIGHT:     fh_q         <= cfg_wdata_i[12:0];
        mpe_pkg::CFG_MAX_ITER:   max_iter_q   <= cfg_wdata_i[15:0];
        mpe_pkg::CFG_CENTER_RE:  center_re_q  <= cfg_wdata_i;
        mpe_pkg::CFG_CENTER_IM:  center_im_q  <= cfg_wdata_i;
        mpe_pkg::CFG_RANGE_LOW:  range_low_q  <= cfg_wdata_i;
        mpe_pkg::CFG_RANGE_HIGH: range_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q <= pixel_index_i;
      it_q  <= 16'd0;
    end
    if (cmd_i.it_inc) begin
      it_q <= it_q + 16'd1;
    end
    if (cmd_i.div_start) begin
      div_op_q <= cmd_i.div_op;
    end
    if (cmd_i.mul_start) begin
      mul_op_q <= cmd_i.mul_op;
    end
    if (div_done) begin
      case (div_op_q)
        mpe_pkg::DO_XY: begin
          x_q <= 13'(div_rem);
          y_q <= div_quo[23:0];
        end
        mpe_pkg::DO_S:  s_q     <= ratio;
        mpe_pkg::DO_RX: ratio_q <= ratio;
        mpe_pkg::DO_RY: ratio_q <= ratio;
        default: ;
      endcase
    end
    if (mul_done) begin
      case (mul_op_q)
        mpe_pkg::MO_TX, mpe_pkg::MO_TY: t_q <= mpe_pkg::qadd(range_low_q, mul_res);
        mpe_pkg::MO_CRE: begin
          cre_q <= mpe_pkg::qsub(mul_res, center_re_q);
          zr_q  <= mpe_pkg::qsub(mul_res, center_re_q);
        end
        mpe_pkg::MO_CIM: begin
          cim_q <= mpe_pkg::qsub(mul_res, center_im_q);
          zi_q  <= mpe_pkg::qsub(mul_res, center_im_q);
        end
        mpe_pkg::MO_RR: rr_q <= mul_res;
        mpe_pkg::MO_II: ii_q <= mul_res;
        mpe_pkg::MO_RI: ri_q <= mul_res;
        default: ;
      endcase
    end
    if (cmd_i.update) begin
      zr_q <= mpe_pkg::qadd(mpe_pkg::qsub(rr_q, ii_q), cre_q);
      zi_q <= mpe_pkg::qadd(mpe_pkg::qadd(ri_q, ri_q), cim_q);
    end
    if (cmd_i.set_color) begin
      color_q <= {mpe_pkg::ALPHA, mpe_pkg::FIRE_ROM[{it_q[5:0], 2'b00}]};
    end
    if (cmd_i.set_black) begin
      color_q <= {mpe_pkg::ALPHA, 24'd0};
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.mul_done = mul_done;
  assign sts_o.last     = (it_q == max_iter_q);
  assign sts_o.escaped  = (mag2 > FOUR);

  assign out_index_o  = idx_q;
  assign argb_color_o = color_q;

endmodule

/* design/mpe_ctrl.sv */
// Controller: sequences the divider and multiplier through setup and iterations.
// Depends on mpe_pkg.
module mpe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  mpe_pkg::sts_t sts_i,
  output mpe_pkg::cmd_t cmd_o,
  output logic          busy_o,
  output logic          done_o
);

  mpe_pkg::state_e state_q, state_d;
  logic launch_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      mpe_pkg::ST_IDLE:    if (start_i) state_d = mpe_pkg::ST_DIV_XY;
      mpe_pkg::ST_DIV_XY:  if (sts_i.div_done) state_d = mpe_pkg::ST_DIV_S;
      mpe_pkg::ST_DIV_S:   if (sts_i.div_done) state_d = mpe_pkg::ST_DIV_RX;
      mpe_pkg::ST_DIV_RX:  if (sts_i.div_done) state_d = mpe_pkg::ST_MUL_TX;
      mpe_pkg::ST_MUL_TX:  if (sts_i.mul_done) state_d = mpe_pkg::ST_MUL_CRE;
      mpe_pkg::ST_MUL_CRE: if (sts_i.mul_done) state_d = mpe_pkg::ST_DIV_RY;
      mpe_pkg::ST_DIV_RY:  if (sts_i.div_done) state_d = mpe_pkg::ST_MUL_TY;
      mpe_pkg::ST_MUL_TY:  if (sts_i.mul_done) state_d = mpe_pkg::ST_MUL_CIM;
      mpe_pkg::ST_MUL_CIM: if (sts_i.mul_done) state_d = mpe_pkg::ST_MUL_RR0;
      mpe_pkg::ST_MUL_RR0: if (sts_i.mul_done) state_d = mpe_pkg::ST_MUL_II0;
      mpe_pkg::ST_MUL_II0: if (sts_i.mul_done) state_d = mpe_pkg::ST_LOOP;
      mpe_pkg::ST_LOOP:    state_d = sts_i.last ? mpe_pkg::ST_DONE : mpe_pkg::ST_MUL_RI;
      mpe_pkg::ST_MUL_RI:  if (sts_i.mul_done) state_d = mpe_pkg::ST_UPDATE;
      mpe_pkg::ST_UPDATE:  state_d = mpe_pkg::ST_MUL_RR;
      mpe_pkg::ST_MUL_RR:  if (sts_i.mul_done) state_d = mpe_pkg::ST_MUL_II;
      mpe_pkg::ST_MUL_II:  if (sts_i.mul_done) state_d = mpe_pkg::ST_CHECK;
      mpe_pkg::ST_CHECK:   state_d = sts_i.escaped ? mpe_pkg::ST_DONE : mpe_pkg::ST_LOOP;
      mpe_pkg::ST_DONE:    state_d = mpe_pkg::ST_IDLE;
      default:             state_d = mpe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '{load: 1'b0, div_start: 1'b0, div_op: mpe_pkg::DO_XY, mul_start: 1'b0,
              mul_op: mpe_pkg::MO_RR, update: 1'b0, it_inc: 1'b0, set_color: 1'b0,
              set_black: 1'b0};
    case (state_q)
      mpe_pkg::ST_IDLE: cmd_o.load = start_i;
      mpe_pkg::ST_DIV_XY: begin
        cmd_o.div_start = launch_q;
        cmd_o.div_op    = mpe_pkg::DO_XY;
      end
      mpe_pkg::ST_DIV_S: begin
        cmd_o.div_start = launch_q;
        cmd_o.div_op    = mpe_pkg::DO_S;
      end
      mpe_pkg::ST_DIV_RX: begin
        cmd_o.div_start = launch_q;
        cmd_o.div_op    = mpe_pkg::DO_RX;
      end
      mpe_pkg::ST_DIV_RY: begin
        cmd_o.div_start = launch_q;
        cmd_o.div_op    = mpe_pkg::DO_RY;
      end
      mpe_pkg::ST_MUL_TX: begin
        cmd_o.mul_start = launch_q;
        cmd_o.mul_op    = mpe_pkg::MO_TX;
      end
      mpe_pkg::ST_MUL_TY: begin
        cmd_o.mul_start = launch_q;
        cmd_o.mul_op    = mpe_pkg::MO_TY;
      end
      mpe_pkg::ST_MUL_CRE: begin
        cmd_o.mul_start = launch_q;
        cmd_o.mul_op    = mpe_pkg::MO_CRE;
      end
      mpe_pkg::ST_MUL_CIM: begin
        cmd_o.mul_start = launch_q;
        cmd_o.mul_op    = mpe_pkg::MO_CIM;
      end
      mpe_pkg::ST_MUL_RR0, mpe_pkg::ST_MUL_RR: begin
        cmd_o.mul_start = launch_q;
        cmd_o.mul_op    = mpe_pkg::MO_RR;
      end
      mpe_pkg::ST_MUL_II0, mpe_pkg::ST_MUL_II: begin
        cmd_o.mul_start = launch_q;
        cmd_o.mul_op    = mpe_pkg::MO_II;
      end
      mpe_pkg::ST_MUL_RI: begin
        cmd_o.mul_start = launch_q;
        cmd_o.mul_op    = mpe_pkg::MO_RI;
      end
      mpe_pkg::ST_LOOP:   cmd_o.set_black = sts_i.last;
      mpe_pkg::ST_UPDATE: cmd_o.update = 1'b1;
      mpe_pkg::ST_CHECK: begin
        cmd_o.set_color = sts_i.escaped;
        cmd_o.it_inc    = !sts_i.escaped;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mpe_pkg::ST_IDLE;
      launch_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      // one start pulse on the first cycle of each unit state
      launch_q <= (state_d != state_q);
    end
  end

  assign busy_o = (state_q != mpe_pkg::ST_IDLE);
  assign done_o = (state_q == mpe_pkg::ST_DONE);

endmodule

/* design/mandelbrot_pixel_engine_top.sv */
// Mandelbrot escape-time pixel engine, top level.
// Depends on mpe_pkg, mpe_ctrl and mpe_dp.
//
// Takes a pixel index when start_i is high and busy_o is low, and returns its
// index and ARGB color with a one-cycle done_o strobe that cannot be stalled.
// One item at a time: setup runs three fractional divisions through the
// one-bit-per-cycle divider plus one integer division and six multiplies; each
// orbit iteration then runs three products through the shared 24x24
// multiplier. The final limit test and the done state close each item.
// Config writes must happen while busy_o is low.
module mandelbrot_pixel_engine_top #(
  parameter int unsigned MAX_DIM   = 4096,
  parameter int unsigned FRAC_BITS = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [47:0] cfg_wdata_i,
  input  logic        start_i,
  input  logic [23:0] pixel_index_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [23:0] out_index_o,
  output logic [31:0] argb_color_o
);

  mpe_pkg::cmd_t cmd;
  mpe_pkg::sts_t sts;

  mpe_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  mpe_dp #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_DIM   (MAX_DIM)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pixel_index_i (pixel_index_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_index_o   (out_index_o),
    .argb_color_o  (argb_color_o)
  );

endmodule

/* design/mpe_checker.sv */
// Port-level checks of the Mandelbrot pixel engine, bound to the top level.
// Depends on mandelbrot_pixel_engine_top_assert.svh.
`include "mandelbrot_pixel_engine_top_assert.svh"

module mpe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [31:0] argb_color_o
);

  `MPE_ASSERT(a_start_busy, start_i && !busy_o |=> busy_o, "accepted item did not raise busy")
  `MPE_ASSERT(a_done_single, done_o |=> !done_o && !busy_o, "done not a single pulse")
  `MPE_ASSERT(a_busy_end, $fell(busy_o) |-> $past(done_o), "busy dropped without a result")
  `MPE_ASSERT(a_alpha, done_o |-> argb_color_o[31:24] == 8'hFF, "alpha not opaque")
  `MPE_ASSERT_ALWAYS(a_done_busy, done_o |-> busy_o, "result outside a busy period")

endmodule

bind mandelbrot_pixel_engine_top mpe_checker u_mpe_checker (.*);

/* verif/mandelbrot_pixel_engine_top_tb.sv */
// Testbench for mandelbrot_pixel_engine_top: directed and random pixel items
// checked against a fixed-point escape-time predictor in a small scoreboard class.
// Depends on mpe_pkg and the engine RTL.
`timescale 1ns / 1ps

module mandelbrot_pixel_engine_top_tb;

  localparam int FRAC = 40;
  localparam int DIM_MAX = 4096;
  localparam longint CYCLE_LIMIT = 40_000_000;

  typedef logic signed [47:0] q_t;

  class escape_scoreboard;
    logic [12:0] width, height;
    logic [15:0] iter_limit;
    q_t ctr_re, ctr_im, lo, hi;
    logic [23:0] idx_q[$];
    logic [31:0] color_q[$];
    int errors;

    function void defaults();
      width = 640; height = 480; iter_limit = 200;
      ctr_re = q_t'(64'sd1 <<< (FRAC - 1)); ctr_im = '0;
      lo = q_t'(-(64'sd2 <<< FRAC)); hi = q_t'(64'sd2 <<< FRAC);
      errors = 0;
    endfunction

    function void set_reg(mpe_pkg::cfg_idx_e r, logic [47:0] v);
      case (r)
        mpe_pkg::CFG_WIDTH:      width = v[12:0];
        mpe_pkg::CFG_HEIGHT:     height = v[12:0];
        mpe_pkg::CFG_MAX_ITER:   iter_limit = v[15:0];
        mpe_pkg::CFG_CENTER_RE:  ctr_re = v;
        mpe_pkg::CFG_CENTER_IM:  ctr_im = v;
        mpe_pkg::CFG_RANGE_LOW:  lo = v;
        mpe_pkg::CFG_RANGE_HIGH: hi = v;
        default: ;
      endcase
    endfunction

    function q_t sat_add(q_t a, q_t b, bit sub);
      logic signed [48:0] s;
      s = sub ? (49'(a) - 49'(b)) : (49'(a) + 49'(b));
      if (s > 49'sh7FFF_FFFF_FFFF) return q_t'(mpe_pkg::QMAX);
      if (s < -49'sh8000_0000_0000) return q_t'(mpe_pkg::QMIN);
      return s[47:0];
    endfunction

    // full product, floor shift, saturate
    function q_t fmul(q_t a, q_t b);
      logic signed [95:0] p;
      p = a * b;
      p = p >>> FRAC;
      if (p > 96'sh7FFF_FFFF_FFFF) return q_t'(mpe_pkg::QMAX);
      if (p < -96'sh8000_0000_0000) return q_t'(mpe_pkg::QMIN);
      return p[47:0];
    endfunction

    function q_t ratio(longint unsigned num, longint unsigned den);
      logic [127:0] n;
      if (num / den > 127) return q_t'(mpe_pkg::QMAX);
      n = 128'(num) << FRAC;
      n = n / den;
      return n[47:0];
    endfunction

    function logic [31:0] pixel_color(logic [23:0] idx);
      longint unsigned w, h, x, y;
      q_t span, s, tre, tim, cre, cim, zr, zi, rr, ii, ri;
      logic signed [49:0] mag;
      w = (width == 0) ? 1 : ((width > DIM_MAX) ? DIM_MAX : width);
      h = (height == 0) ? 1 : ((height > DIM_MAX) ? DIM_MAX : height);
      x = idx % w;
      y = idx / w;
      span = sat_add(hi, lo, 1);
      s = ratio(4 * w, 5 * h);
      tre = sat_add(lo, fmul(span, ratio(x, w)), 0);
      tim = sat_add(lo, fmul(span, ratio(y, h)), 0);
      cre = sat_add(fmul(s, tre), ctr_re, 1);
      cim = sat_add(fmul(s, tim), ctr_im, 1);
      zr = cre; zi = cim;
      for (int it = 0; it < iter_limit; it++) begin
        rr = fmul(zr, zr); ii = fmul(zi, zi); ri = fmul(zr, zi);
        zr = sat_add(sat_add(rr, ii, 1), cre, 0);
        zi = sat_add(sat_add(ri, ri, 0), cim, 0);
        mag = 50'(fmul(zr, zr)) + 50'(fmul(zi, zi));
        if (mag > (50'sd4 <<< FRAC))
          return {mpe_pkg::ALPHA, mpe_pkg::FIRE_ROM[(4 * it) % 256]};
      end
      return {mpe_pkg::ALPHA, 24'd0};
    endfunction

    function void note_item(logic [23:0] idx);
      idx_q.push_back(idx);
      color_q.push_back(pixel_color(idx));
    endfunction

    function void check_result(logic [23:0] idx, logic [31:0] color);
      logic [23:0] e_idx;
      logic [31:0] e_col;
      if (idx_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result idx=%0d color=%h", idx, color);
        return;
      end
      e_idx = idx_q.pop_front();
      e_col = color_q.pop_front();
      if (idx !== e_idx || color !== e_col) begin
        errors++;
        if (errors <= 10)
          $display("result differs: idx exp %0d got %0d, color exp %h got %h",
                   e_idx, idx, e_col, color);
      end
    endfunction

    function int pending();
      return idx_q.size();
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0, start_i = 0;
  logic [2:0] cfg_idx_i = '0;
  logic [47:0] cfg_wdata_i = '0;
  logic [23:0] pixel_index_i = '0;
  logic busy_o, done_o;
  logic [23:0] out_index_o;
  logic [31:0] argb_color_o;
  longint cycles = 0;
  logic [12:0] cur_w, cur_h;

  escape_scoreboard sb;

  mandelbrot_pixel_engine_top dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("mandelbrot_pixel_engine_top: mismatch");
      $finish;
    end
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_item(pixel_index_i);
      if (done_o) sb.check_result(out_index_o, argb_color_o);
    end
  end

  task automatic write_reg(mpe_pkg::cfg_idx_e r, logic [47:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= r; cfg_wdata_i <= v;
    sb.set_reg(r, v);
    if (r == mpe_pkg::CFG_WIDTH) cur_w = v[12:0];
    if (r == mpe_pkg::CFG_HEIGHT) cur_h = v[12:0];
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  // busy_o is checked at the falling edge, so the item goes in at the next rising edge
  task automatic push(logic [23:0] idx);
    @(negedge clk_i);
    start_i <= 1; pixel_index_i <= idx;
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic pause(int n);
    @(negedge clk_i);
    start_i <= 0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain();
    pause(0);
    while (sb.pending() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [47:0] small_q();
    // within about +-2.0
    return 48'(longint'($urandom_range(0, 32'hFFFF_FFFF)) * 1024) - 48'(64'sd2 <<< FRAC);
  endfunction

  function automatic logic [47:0] any_q();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic logic [12:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return 13'd1;
      1: return 13'd4096;
      2: return 13'd0;
      3: return 13'($urandom_range(4097, 8191));
      default: return 13'($urandom_range(1, 64));
    endcase
  endfunction

  initial begin
    int area, burst;
    sb = new();
    sb.defaults();
    cur_w = 640; cur_h = 480;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1;

    // defaults: corners, an interior point, one far beyond the frame
    push(0); push(640 * 480 - 1); push(240 * 640 + 200); push(24'hFF_FFFF);
    drain();
    write_reg(mpe_pkg::CFG_MAX_ITER, 0);
    push(5); push(24'h80_0000);
    drain();
    // degenerate dimensions clamp
    write_reg(mpe_pkg::CFG_WIDTH, 0); write_reg(mpe_pkg::CFG_HEIGHT, 13'h1FFF);
    write_reg(mpe_pkg::CFG_MAX_ITER, 8);
    push(0); push(3); push(24'hAA_AAAA);
    drain();
    write_reg(mpe_pkg::CFG_WIDTH, 13'h1FFF); write_reg(mpe_pkg::CFG_HEIGHT, 0);
    push(4095); push(4096); push(24'h55_5555);
    drain();
    // saturated span and centers, long limit but every point leaves at once
    write_reg(mpe_pkg::CFG_WIDTH, 4096); write_reg(mpe_pkg::CFG_HEIGHT, 4096);
    write_reg(mpe_pkg::CFG_RANGE_LOW, mpe_pkg::QMIN);
    write_reg(mpe_pkg::CFG_RANGE_HIGH, mpe_pkg::QMAX);
    write_reg(mpe_pkg::CFG_CENTER_RE, mpe_pkg::QMIN);
    write_reg(mpe_pkg::CFG_CENTER_IM, mpe_pkg::QMAX);
    write_reg(mpe_pkg::CFG_MAX_ITER, 16'hFFFF);
    push(0); push(24'hFF_FFFF); push(4096 * 2048 + 2048);
    drain();
    write_reg(mpe_pkg::CFG_CENTER_RE, mpe_pkg::QMAX);
    write_reg(mpe_pkg::CFG_CENTER_IM, mpe_pkg::QMIN);
    write_reg(mpe_pkg::CFG_RANGE_LOW, mpe_pkg::QMAX);
    write_reg(mpe_pkg::CFG_RANGE_HIGH, mpe_pkg::QMIN);
    push(1); push(24'h7F_FFFF);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      write_reg(mpe_pkg::CFG_WIDTH, pick_dim());
      write_reg(mpe_pkg::CFG_HEIGHT, pick_dim());
      write_reg(mpe_pkg::CFG_MAX_ITER, 48'($urandom_range(0, 12)));
      if ($urandom_range(0, 3) == 0) begin
        write_reg(mpe_pkg::CFG_CENTER_RE, any_q()); write_reg(mpe_pkg::CFG_CENTER_IM, any_q());
        write_reg(mpe_pkg::CFG_RANGE_LOW, any_q()); write_reg(mpe_pkg::CFG_RANGE_HIGH, any_q());
      end else begin
        write_reg(mpe_pkg::CFG_CENTER_RE, $signed(small_q()) >>> 1);
        write_reg(mpe_pkg::CFG_CENTER_IM, $signed(small_q()) >>> 1);
        write_reg(mpe_pkg::CFG_RANGE_LOW, small_q());
        write_reg(mpe_pkg::CFG_RANGE_HIGH, small_q());
      end
      area = ((cur_w == 0) ? 1 : (cur_w > 4096 ? 4096 : cur_w)) *
             ((cur_h == 0) ? 1 : (cur_h > 4096 ? 4096 : cur_h));
      for (int n = 0; n < 200; ) begin
        burst = $urandom_range(1, 12);
        for (int k = 0; k < burst; k++, n++) begin
          if ($urandom_range(0, 9) == 0) push(24'($urandom));
          else push(24'($urandom_range(0, area - 1)));
        end
        if ($urandom_range(0, 2) != 0) pause($urandom_range(0, 300));
      end
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("mandelbrot_pixel_engine_top: match");
    else
      $display("mandelbrot_pixel_engine_top: mismatch");
    $finish;
  end
endmodule

/* files.f */
+incdir+design
design/mpe_pkg.sv
design/mpe_mul.sv
design/mpe_div.sv
design/mpe_dp.sv
design/mpe_ctrl.sv
design/mandelbrot_pixel_engine_top.sv
design/mpe_checker.sv
verif/mandelbrot_pixel_engine_top_tb.sv
